// File: rtl/core/cmpt_pkg.sv
// Shared types, widths and helpers for the cubic Mandelbrot point test.
// No dependencies; cmpt_cell, cmpt_tail and the top use it by scoped names.
package cmpt_pkg;

	localparam int COORD_W = 31;
	localparam int Z_W     = 32;
	localparam int PROD_W  = 2 * Z_W;
	localparam int LIMIT_W = 31;
	localparam int WIDE_W  = 64;

	localparam logic signed [WIDE_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [WIDE_W-1:0] SAT_LO = -64'sh0000_0000_8000_0000;

	// One point in flight: current z, the constant c and the escape flag.
	typedef struct packed {
		logic signed [Z_W-1:0]     zx;
		logic signed [Z_W-1:0]     zy;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic                      escaped;
	} point_t;

	// Clamp a wide signed value to the 32-bit signed range.
	function automatic logic signed [Z_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [Z_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[Z_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[Z_W-1:0];
		end else begin
			r = v[Z_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/cmpt_cell.sv
// One iteration z = z^3 + c as a three-stage cell, with the escape check of
// the z it receives. Depends on cmpt_pkg.
module cmpt_cell #(
	parameter int FRACTION_BITS = 28
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic [cmpt_pkg::LIMIT_W-1:0]      limit,
	input  logic                              in_valid,
	input  cmpt_pkg::point_t                  in_pt,
	output logic                              out_valid,
	output cmpt_pkg::point_t                  out_pt
);

	localparam int SQ_W = cmpt_pkg::PROD_W - FRACTION_BITS;
	localparam int ZW   = cmpt_pkg::Z_W;
	localparam int TW   = ZW + 2;

	// stage 1: squares of z
	logic signed [cmpt_pkg::PROD_W-1:0] prod_x, prod_y;
	logic                               v_s1;
	cmpt_pkg::point_t                   pt_s1;
	logic [SQ_W-1:0]                    sqx_s1, sqy_s1;

	// stage 2: magnitude check and real/imaginary factors
	logic [SQ_W:0]          mag;
	logic [ZW-2:0]          x2, y2;
	logic [TW-1:0]          ax, ay, ax3, ay3;
	logic signed [TW-1:0]   re_w, im_w;
	logic                   v_s2;
	cmpt_pkg::point_t       pt_s2;
	logic signed [ZW-1:0]   re_s2, im_s2;

	// stage 3: multiply by z, add c
	logic signed [cmpt_pkg::PROD_W-1:0] prx, pry;
	logic signed [cmpt_pkg::PROD_W-1:0] shx, shy;
	logic signed [ZW-1:0]               tx, ty;
	logic signed [ZW:0]                 sumx, sumy;
	logic                               v_s3;
	cmpt_pkg::point_t                   pt_s3;

	always_comb begin
		prod_x = in_pt.zx * in_pt.zx;
		prod_y = in_pt.zy * in_pt.zy;
	end

	always_comb begin
		mag  = {1'b0, sqx_s1} + {1'b0, sqy_s1};
		x2   = (|sqx_s1[SQ_W-1:ZW-1]) ? '1 : sqx_s1[ZW-2:0];
		y2   = (|sqy_s1[SQ_W-1:ZW-1]) ? '1 : sqy_s1[ZW-2:0];
		ax   = {3'b000, x2};
		ay   = {3'b000, y2};
		ax3  = (ax << 1) + ax;
		ay3  = (ay << 1) + ay;
		re_w = $signed(ax - ay3);
		im_w = $signed(ax3 - ay);
	end

	always_comb begin
		prx  = re_s2 * pt_s2.zx;
		pry  = im_s2 * pt_s2.zy;
		shx  = prx >>> FRACTION_BITS;
		shy  = pry >>> FRACTION_BITS;
		tx   = cmpt_pkg::sat32(shx);
		ty   = cmpt_pkg::sat32(shy);
		sumx = (ZW+1)'(tx) + (ZW+1)'(pt_s2.cx);
		sumy = (ZW+1)'(ty) + (ZW+1)'(pt_s2.cy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pt_s1  <= in_pt;
			sqx_s1 <= prod_x[cmpt_pkg::PROD_W-1:FRACTION_BITS];
			sqy_s1 <= prod_y[cmpt_pkg::PROD_W-1:FRACTION_BITS];

			pt_s2.zx      <= pt_s1.zx;
			pt_s2.zy      <= pt_s1.zy;
			pt_s2.cx      <= pt_s1.cx;
			pt_s2.cy      <= pt_s1.cy;
			pt_s2.escaped <= pt_s1.escaped | (mag > (SQ_W+1)'(limit));
			re_s2         <= cmpt_pkg::sat32(cmpt_pkg::WIDE_W'(re_w));
			im_s2         <= cmpt_pkg::sat32(cmpt_pkg::WIDE_W'(im_w));

			pt_s3.cx      <= pt_s2.cx;
			pt_s3.cy      <= pt_s2.cy;
			pt_s3.escaped <= pt_s2.escaped;
			pt_s3.zx      <= cmpt_pkg::sat32(cmpt_pkg::WIDE_W'(sumx));
			pt_s3.zy      <= cmpt_pkg::sat32(cmpt_pkg::WIDE_W'(sumy));
		end
	end

	assign out_valid = v_s3;
	assign out_pt    = pt_s3;

endmodule

// File: rtl/core/cmpt_tail.sv
// Final magnitude test after the last iteration: square, sum, compare.
// Depends on cmpt_pkg.
module cmpt_tail #(
	parameter int FRACTION_BITS = 28
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [cmpt_pkg::LIMIT_W-1:0]  limit,
	input  logic                          in_valid,
	input  cmpt_pkg::point_t              in_pt,
	output logic                          out_valid,
	output logic                          out_inside
);

	localparam int SQ_W = cmpt_pkg::PROD_W - FRACTION_BITS;

	logic signed [cmpt_pkg::PROD_W-1:0] prod_x, prod_y;
	logic                               v_s1, esc_s1;
	logic [SQ_W-1:0]                    sqx_s1, sqy_s1;
	logic [SQ_W:0]                      mag;
	logic                               v_s2, inside_s2;

	always_comb begin
		prod_x = in_pt.zx * in_pt.zx;
		prod_y = in_pt.zy * in_pt.zy;
		mag    = {1'b0, sqx_s1} + {1'b0, sqy_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			esc_s1    <= in_pt.escaped;
			sqx_s1    <= prod_x[cmpt_pkg::PROD_W-1:FRACTION_BITS];
			sqy_s1    <= prod_y[cmpt_pkg::PROD_W-1:FRACTION_BITS];
			inside_s2 <= ~esc_s1 & (mag < (SQ_W+1)'(limit));
		end
	end

	assign out_valid  = v_s2;
	assign out_inside = inside_s2;

endmodule

// File: rtl/core/cmpt_outq.sv
// Two-word output queue that parts the pipeline from the output stall.
// No package dependency.
module cmpt_outq (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic push_data,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output logic out_data
);

	logic [1:0] data_q;
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign pop       = out_valid & ~out_stall;
	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign out_data  = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/core/cubic_mandelbrot_point_test_top.sv
// Cubic Mandelbrot escape test: a row of ITERATIONS iteration cells, a final
// magnitude stage and a two-word output queue. Depends on cmpt_pkg,
// cmpt_cell, cmpt_tail and cmpt_outq.
//
// A point c = x_coord + i*y_coord (signed Q3.28 by default) enters and runs
// z = z^3 + c from z = 0 through ITERATIONS identical cells, one cell per
// iteration, each cell three register stages deep (squares, escape check
// with the real/imaginary factors, multiply by z and add c). Values saturate
// to 32 bits instead of wrapping; a point whose |z|^2 ever exceeds the limit
// is marked escaped and answers 0. inside_res is 1 when the point never
// escaped and its final |z|^2 is strictly below magnitude_squared_limit.
// One point is accepted per clock cycle whenever the output queue is not
// full; a point passes through the row of cells and the final magnitude
// stage, then waits in the queue. The whole pipeline holds while the
// two-word output queue is full, so a finished word may wait at the
// output while the next point still enters.
// Write magnitude_squared_limit (byte address 0, 31 bits) only while no
// point is in flight.
module cubic_mandelbrot_point_test_top #(
	parameter int ITERATIONS    = 200,
	parameter int FRACTION_BITS = 28
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [2:0]                           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	// point input
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [cmpt_pkg::COORD_W-1:0]  x_coord,
	input  logic signed [cmpt_pkg::COORD_W-1:0]  y_coord,
	// result output
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 inside_res
);

	localparam logic                         REG_LIMIT   = 1'b0;
	localparam logic [cmpt_pkg::LIMIT_W-1:0] LIMIT_RESET = 31'h4000_0000;

	logic [cmpt_pkg::LIMIT_W-1:0] limit_q;
	logic                         cfg_wr;
	logic                         advance;
	logic                         q_full;
	logic                         tail_valid, tail_inside;

	logic             valid_chain [ITERATIONS+1];
	cmpt_pkg::point_t pt_chain    [ITERATIONS+1];

	// Configuration: one register, selected by the word address bit.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == REG_LIMIT) ? {1'b0, limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr && paddr[2] == REG_LIMIT) begin
			limit_q <= pwdata[cmpt_pkg::LIMIT_W-1:0];
		end
	end

	// Advance the whole row together; hold it only while the queue is full.
	assign advance  = ~q_full;
	assign in_stall = q_full;

	// Seed the first cell: z starts at zero, not escaped.
	always_comb begin
		valid_chain[0]       = in_valid & ~in_stall;
		pt_chain[0].zx       = '0;
		pt_chain[0].zy       = '0;
		pt_chain[0].cx       = x_coord;
		pt_chain[0].cy       = y_coord;
		pt_chain[0].escaped  = 1'b0;
	end

	for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
		cmpt_cell #(
			.FRACTION_BITS(FRACTION_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.limit    (limit_q),
			.in_valid (valid_chain[k]),
			.in_pt    (pt_chain[k]),
			.out_valid(valid_chain[k+1]),
			.out_pt   (pt_chain[k+1])
		);
	end

	// Final |z|^2 test on the last cell's output.
	cmpt_tail #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.limit     (limit_q),
		.in_valid  (valid_chain[ITERATIONS]),
		.in_pt     (pt_chain[ITERATIONS]),
		.out_valid (tail_valid),
		.out_inside(tail_inside)
	);

	// Drop finished words into the queue; it drives the output channel.
	cmpt_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (tail_valid & advance),
		.push_data(tail_inside),
		.full     (q_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (inside_res)
	);

endmodule
